@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the parser RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

@@ design/rrp_pkg.sv @@
// ----------------------------------------------------------------------------
// rrp_pkg
// Types and constants shared by the request parser modules.
// ----------------------------------------------------------------------------
package rrp_pkg;

    localparam int COUNT_BITS_DEF = 31;
    localparam int ARG_W          = 31;
    localparam int Q_DEPTH        = 2;

    localparam int IN_TDATA_W  = 8;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_TUSER_W = 3;

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [1:0] ST_FRAME = 2'd0;
    localparam logic [1:0] ST_DATA  = 2'd1;
    localparam logic [1:0] ST_ARG   = 2'd2;
    localparam logic [1:0] ST_ERR   = 2'd3;

    // Classified input item as it travels through the queue
    typedef struct packed {
        logic       clr;
        logic [7:0] byte_in;
        logic       is_star;
        logic       is_dollar;
        logic       is_cr;
        logic       is_lf;
        logic       is_minus;
        logic       is_digit;
        logic [3:0] digit;
    } t_item;

    typedef struct packed {
        logic [1:0]       status;
        logic [7:0]       data;
        logic [ARG_W-1:0] arg_index;
        logic             null_arg;
        logic             request_done;
    } t_result;

endpackage

@@ design/rrp_front.sv @@
// ----------------------------------------------------------------------------
// rrp_front
// Accepts stream transactions and classifies each byte for the back end.
// ----------------------------------------------------------------------------
module rrp_front import rrp_pkg::*; (
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [IN_TDATA_W-1:0] i_data,     // byte_in
    input  logic [IN_TUSER_W-1:0] i_user,     // kind
    input  logic                  i_q_full,
    output logic                  o_push,
    output t_item                 o_item
);

    logic [7:0] b;

    assign b       = i_data[7:0];
    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        o_item           = '0;
        o_item.clr       = i_user[0];
        o_item.byte_in   = b;
        o_item.is_star   = (b == CH_STAR);
        o_item.is_dollar = (b == CH_DOLLAR);
        o_item.is_cr     = (b == CH_CR);
        o_item.is_lf     = (b == CH_LF);
        o_item.is_minus  = (b == CH_MINUS);
        o_item.is_digit  = (b >= CH_ZERO) && (b <= CH_NINE);
        o_item.digit     = 4'(b - CH_ZERO);
    end

endmodule

@@ design/rrp_queue.sv @@
// ----------------------------------------------------------------------------
// rrp_queue
// Short queue of classified items between front and back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rrp_queue import rrp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_pop
);

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_item         r_mem [Q_DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count,  n_count;

    assign o_full  = (r_count == CW'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    `ASSERT_NEVER(a_q_no_overflow, i_push && o_full, "queue push while full")
    `ASSERT_NEVER(a_q_no_underflow, i_pop && !o_valid, "queue pop while empty")
    `ASSERT_NEVER(a_q_count_range, r_count > CW'(Q_DEPTH), "queue count out of range")

endmodule

@@ design/rrp_back.sv @@
// ----------------------------------------------------------------------------
// rrp_back
// Request state machine: count accumulation, payload tracking, result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rrp_back import rrp_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_item_valid,
    input  t_item   i_item,
    output logic    o_item_pop,
    output logic    o_res_valid,
    output t_result o_res,
    input  logic    i_res_ready
);

    localparam int CB = COUNT_BITS;
    localparam int VW = COUNT_BITS + 4;
    localparam logic [CB-1:0] COUNT_MAX = '1;

    localparam logic [3:0] PH_STAR   = 4'd0;
    localparam logic [3:0] PH_ANUM   = 4'd1;
    localparam logic [3:0] PH_ALF    = 4'd2;
    localparam logic [3:0] PH_DOLLAR = 4'd3;
    localparam logic [3:0] PH_LNUM   = 4'd4;
    localparam logic [3:0] PH_LLF    = 4'd5;
    localparam logic [3:0] PH_DATA   = 4'd6;
    localparam logic [3:0] PH_DCR    = 4'd7;
    localparam logic [3:0] PH_DLF    = 4'd8;
    localparam logic [3:0] PH_ERR    = 4'd9;

    logic [3:0]    r_phase,     n_phase;
    logic [CB-1:0] r_acc,       n_acc;
    logic          r_neg,       n_neg;
    logic          r_seen,      n_seen;
    logic [CB-1:0] r_args_exp,  n_args_exp;
    logic [CB-1:0] r_args_done, n_args_done;
    logic [CB-1:0] r_left,      n_left;
    logic          r_out_valid;
    t_result       r_out;
    t_result       res;

    logic [VW-1:0] acc_x10;
    logic [VW-1:0] limit;
    logic          num_minus, num_digit, num_end, num_bad;
    logic [CB-1:0] args_inc;
    logic          last_arg;
    logic          pop;

    assign pop         = i_item_valid && (!r_out_valid || i_res_ready);
    assign o_item_pop  = pop;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    // times ten as two shifted adds, plus the new digit
    assign acc_x10  = (VW'(r_acc) << 3) + (VW'(r_acc) << 1) + VW'(i_item.digit);
    assign limit    = r_neg ? VW'(1) : VW'(COUNT_MAX);
    assign args_inc = r_args_done + CB'(1);
    assign last_arg = (args_inc >= r_args_exp);

    // classify one byte of a count field
    always_comb begin
        num_minus = 1'b0;
        num_digit = 1'b0;
        num_end   = 1'b0;
        num_bad   = 1'b0;
        if (i_item.is_minus && !r_seen && !r_neg) begin
            num_minus = 1'b1;
        end else if (i_item.is_digit) begin
            if (acc_x10 > limit) begin
                num_bad = 1'b1;
            end else begin
                num_digit = 1'b1;
            end
        end else if (i_item.is_cr && r_seen) begin
            num_end = 1'b1;
        end else begin
            num_bad = 1'b1;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_acc       = r_acc;
        n_neg       = r_neg;
        n_seen      = r_seen;
        n_args_exp  = r_args_exp;
        n_args_done = r_args_done;
        n_left      = r_left;
        res              = '0;
        res.status       = ST_FRAME;
        res.arg_index    = ARG_W'(r_args_done);

        if (i_item.clr) begin
            n_phase     = PH_STAR;
            n_acc       = '0;
            n_neg       = 1'b0;
            n_seen      = 1'b0;
            n_args_exp  = '0;
            n_args_done = '0;
            n_left      = '0;
            res.arg_index = '0;
        end else begin
            unique case (r_phase)
                PH_STAR, PH_DOLLAR: begin
                    if ((r_phase == PH_STAR) ? i_item.is_star : i_item.is_dollar) begin
                        n_acc   = '0;
                        n_neg   = 1'b0;
                        n_seen  = 1'b0;
                        n_phase = (r_phase == PH_STAR) ? PH_ANUM : PH_LNUM;
                    end else begin
                        n_phase = PH_ERR;
                    end
                end
                PH_ANUM, PH_LNUM: begin
                    if (num_minus) begin
                        n_neg = 1'b1;
                    end
                    if (num_digit) begin
                        n_acc  = acc_x10[CB-1:0];
                        n_seen = 1'b1;
                    end
                    if (num_bad) begin
                        n_phase = PH_ERR;
                    end else if (num_end) begin
                        n_phase = (r_phase == PH_ANUM) ? PH_ALF : PH_LLF;
                    end
                end
                PH_ALF: begin
                    if (!i_item.is_lf) begin
                        n_phase = PH_ERR;
                    end else begin
                        n_args_done   = '0;
                        res.arg_index = '0;
                        if (r_neg || r_acc == '0) begin
                            n_args_exp       = '0;
                            res.request_done = 1'b1;
                            n_phase          = PH_STAR;
                        end else begin
                            n_args_exp = r_acc;
                            n_phase    = PH_DOLLAR;
                        end
                    end
                end
                PH_LLF: begin
                    if (!i_item.is_lf) begin
                        n_phase = PH_ERR;
                    end else if (r_neg && r_acc == CB'(1)) begin
                        // null argument
                        res.status       = ST_ARG;
                        res.null_arg     = 1'b1;
                        n_args_done      = args_inc;
                        res.request_done = last_arg;
                        n_phase          = last_arg ? PH_STAR : PH_DOLLAR;
                    end else begin
                        n_left  = r_neg ? '0 : r_acc;
                        n_phase = (r_neg || r_acc == '0) ? PH_DCR : PH_DATA;
                    end
                end
                PH_DATA: begin
                    res.status = ST_DATA;
                    res.data   = i_item.byte_in;
                    n_left     = r_left - CB'(1);
                    if (r_left == CB'(1)) begin
                        n_phase = PH_DCR;
                    end
                end
                PH_DCR: begin
                    n_phase = i_item.is_cr ? PH_DLF : PH_ERR;
                end
                PH_DLF: begin
                    if (!i_item.is_lf) begin
                        n_phase = PH_ERR;
                    end else begin
                        res.status       = ST_ARG;
                        n_args_done      = args_inc;
                        res.request_done = last_arg;
                        n_phase          = last_arg ? PH_STAR : PH_DOLLAR;
                    end
                end
                default: begin
                    n_phase = PH_ERR;
                end
            endcase
            if (n_phase == PH_ERR) begin
                res              = '0;
                res.status       = ST_ERR;
                res.arg_index    = ARG_W'(n_args_done);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_STAR;
            r_acc       <= '0;
            r_neg       <= 1'b0;
            r_seen      <= 1'b0;
            r_args_exp  <= '0;
            r_args_done <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_phase     <= n_phase;
                r_acc       <= n_acc;
                r_neg       <= n_neg;
                r_seen      <= n_seen;
                r_args_exp  <= n_args_exp;
                r_args_done <= n_args_done;
                r_left      <= n_left;
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out <= res;
        end
    end

    `ASSERT_NEVER(a_args_in_range, ((r_phase == PH_DOLLAR) || (r_phase == PH_LNUM) || (r_phase == PH_LLF) || (r_phase == PH_DATA) || (r_phase == PH_DCR) || (r_phase == PH_DLF)) && (r_args_done >= r_args_exp), "argument count past expected inside a request")
    `ASSERT_NEVER(a_data_only_payload, r_out_valid && (r_out.status != ST_DATA) && (r_out.data != 8'd0), "data nonzero outside payload")
    `ASSERT_NEVER(a_null_is_arg, r_out_valid && r_out.null_arg && (r_out.status != ST_ARG), "null flag without argument complete")
    `ASSERT_NEVER(a_err_not_done, r_out_valid && (r_out.status == ST_ERR) && r_out.request_done, "error result marks request done")

endmodule

@@ design/resp_request_parser.sv @@
// ----------------------------------------------------------------------------
// resp_request_parser
// Byte-serial multibulk request parser. One stream transaction carries one
// request byte (tuser = 0) or a clear (tuser = 1), and each yields exactly one
// result transaction: framing, payload byte, argument complete or error.
// Errors stick until a clear. Sustained rate is one byte per clock while the
// output takes every result. An accepted byte is first written into the
// two-entry queue, and the state update then pops it and loads the result
// register. The state update with its times-ten count accumulate and the
// compare against the count limit is the loop through the state registers
// that sets the byte rate. Input stays ready while a result waits, until the
// queue holds two bytes.
// ----------------------------------------------------------------------------
module resp_request_parser import rrp_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [7:0] byte_in
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,  // [0] kind
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [7:0] data, [38:8] arg_index, [39] zero
    output logic [OUT_TUSER_W-1:0] m_axis_tuser,  // [1:0] status, [2] null_arg
    output logic                   m_axis_tlast   // request_done
);

    t_item   front_item;
    t_item   q_item;
    logic    front_push;
    logic    q_full;
    logic    q_valid;
    logic    q_pop;
    t_result res;

    rrp_front u_front (
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_data   (s_axis_tdata),
        .i_user   (s_axis_tuser),
        .i_q_full (q_full),
        .o_push   (front_push),
        .o_item   (front_item)
    );

    rrp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_item  (front_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    rrp_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (q_valid),
        .i_item       (q_item),
        .o_item_pop   (q_pop),
        .o_res_valid  (m_axis_tvalid),
        .o_res        (res),
        .i_res_ready  (m_axis_tready)
    );

    assign m_axis_tdata = {1'b0, res.arg_index, res.data};
    assign m_axis_tuser = {res.null_arg, res.status};
    assign m_axis_tlast = res.request_done;

endmodule
